// ----- src/eruc_pkg.sv -----
package eruc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_CELLS = 4096;
    localparam int IDX_W     = 12;
    localparam int GAMMA_W   = 19;
    localparam int DT_W      = 17;
    localparam int CFG_W     = GAMMA_W;
    localparam int SPEED_W   = 31;
    localparam int IN_W      = 96;
    localparam int OUT_W     = 144;

    typedef logic signed [31:0] q_t;

    localparam q_t ONE_Q = 32'sd1 <<< FRAC_BITS;

    localparam logic [0:0] CFG_GAMMA = 1'b0;
    localparam logic [0:0] CFG_DT    = 1'b1;

    function automatic q_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return q_t'(32'h7fff_ffff);
        end else if (v < -64'sd2147483648) begin
            return q_t'(32'h8000_0000);
        end
        return q_t'(v[31:0]);
    endfunction

    // arithmetic shift right, rounding toward zero
    function automatic logic signed [63:0] shr_tz(input logic signed [63:0] p, input int n);
        logic signed [63:0] mask;
        logic signed [63:0] t;
        mask = p[63] ? ((64'sd1 <<< n) - 64'sd1) : 64'sd0;
        t    = p + mask;
        return t >>> n;
    endfunction

    function automatic q_t mul_scale(input logic signed [63:0] p);
        return sat32(shr_tz(p, FRAC_BITS));
    endfunction

    function automatic q_t half_tz(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = v + {32'd0, v[32]};
        return q_t'(t >>> 1);
    endfunction

endpackage

// ----- src/euler_rusanov_cell_update.sv -----
// Rusanov (local Lax-Friedrichs) update of a periodic 1D ideal-gas grid, Q16.16.
// Cells arrive one per input transfer; cell k-1 is written out when cell k
// arrives, and the cell marked last (or the one at index 4095) is followed by
// its own result and then by cell 0, which carries tlast. All multiplies run
// on one shared multiplier, and all divides and square roots on one shared
// iterative divide/root unit. Each cell after the first evaluates itself and
// its left neighbor; the last cell also evaluates the first cell. The input
// is not ready while a cell is in work; a result waits in the output register
// while the next cell is taken in.
module euler_rusanov_cell_update (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_density, cell_momentum, cell_energy
    input  logic [eruc_pkg::IN_W-1:0]          s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cell_index, new_density, new_momentum, new_energy, max_wave_speed,
    // state_error, zero pad
    output logic [eruc_pkg::OUT_W-1:0]         m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [0:0]                         cfg_addr,
    input  logic [eruc_pkg::CFG_W-1:0]         cfg_wr_data
);
    import eruc_pkg::*;

    localparam int DVD_W  = 32 + FRAC_BITS;
    localparam int ROOT_W = DVD_W / 2;
    localparam int CNT_W  = $clog2(DVD_W);

    localparam logic [4:0] ST_IDLE       = 5'd0;
    localparam logic [4:0] ST_EV_U       = 5'd1;
    localparam logic [4:0] ST_EV_UD      = 5'd2;
    localparam logic [4:0] ST_EV_MU      = 5'd3;
    localparam logic [4:0] ST_EV_KE      = 5'd4;
    localparam logic [4:0] ST_EV_P       = 5'd5;
    localparam logic [4:0] ST_EV_P2      = 5'd6;
    localparam logic [4:0] ST_EV_F1      = 5'd7;
    localparam logic [4:0] ST_EV_F2M     = 5'd8;
    localparam logic [4:0] ST_EV_F2      = 5'd9;
    localparam logic [4:0] ST_EV_G       = 5'd10;
    localparam logic [4:0] ST_EV_G2      = 5'd11;
    localparam logic [4:0] ST_EV_AD      = 5'd12;
    localparam logic [4:0] ST_EV_C       = 5'd13;
    localparam logic [4:0] ST_EV_SPD     = 5'd14;
    localparam logic [4:0] ST_CUR_DONE   = 5'd15;
    localparam logic [4:0] ST_PREV_DONE  = 5'd16;
    localparam logic [4:0] ST_FACE_M     = 5'd17;
    localparam logic [4:0] ST_FACE_A     = 5'd18;
    localparam logic [4:0] ST_FK_DONE    = 5'd19;
    localparam logic [4:0] ST_AFTER_E1   = 5'd20;
    localparam logic [4:0] ST_FIRST_DONE = 5'd21;
    localparam logic [4:0] ST_FN_DONE    = 5'd22;
    localparam logic [4:0] ST_AFTER_E2   = 5'd23;
    localparam logic [4:0] ST_EMIT_M     = 5'd24;
    localparam logic [4:0] ST_EMIT_A     = 5'd25;
    localparam logic [4:0] ST_EMIT_OUT   = 5'd26;
    localparam logic [4:0] ST_FINISH     = 5'd27;

    logic [4:0]         state_reg, ev_ret_reg, face_ret_reg, emit_ret_reg;
    logic [1:0]         j_reg;
    logic [IDX_W-1:0]   cells_seen_reg, k_reg, em_idx_reg;
    logic               last_reg, em_final_reg;
    logic [SPEED_W-1:0] max_reg;
    logic               err_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [DT_W-1:0]    dt_reg;

    q_t cur_q_reg [3];
    q_t prev_q_reg [3];
    q_t first_q_reg [3];
    q_t prev_if_reg [3];
    q_t first_if_reg [3];
    q_t fc_reg [3];
    q_t lq_reg [3];
    q_t rq_reg [3];
    q_t lf_reg [3];
    q_t rf_reg [3];
    q_t em_c_reg [3];
    q_t em_fl_reg [3];
    q_t em_fr_reg [3];
    q_t res_reg [3];

    logic [SPEED_W-1:0] lsp_reg, rsp_reg, cp_speed_reg, ev_speed_reg;
    q_t cp_f1_reg, cp_f2_reg;
    q_t er_rho_reg, er_m_reg, er_e_reg;
    q_t ev_u_reg, ev_mu_reg, ev_t_reg, ev_p_reg, ev_tmp_reg, ev_f1_reg, ev_f2_reg;
    logic ev_bad_reg;
    logic [ROOT_W-1:0] ev_c_reg;

    logic signed [63:0] prod_reg;

    logic               m_tvalid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    q_t                 out_q_reg [3];
    logic [SPEED_W-1:0] out_speed_reg;
    logic               out_err_reg, out_final_reg;

    // shared divide / root unit
    logic              unit_busy_reg, unit_sqrt_reg, unit_neg_reg;
    logic [CNT_W-1:0]  unit_cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [31:0]       rem_reg, nb_reg;
    logic [ROOT_W-1:0] root_reg;

    logic       unit_start, unit_sqrt;
    q_t         unit_num, unit_den;
    q_t         div_res;
    q_t         mul_a, mul_b;
    q_t         face_diff, emit_diff, face_out, emit_res;
    logic [SPEED_W-1:0] smax, speed_c;
    logic       out_free;
    q_t         mu_c, ke_c;

    function automatic logic [31:0] mag(input q_t v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign smax     = (lsp_reg > rsp_reg) ? lsp_reg : rsp_reg;

    always_comb begin
        logic [32:0] sum;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_EV_MU: begin
                mul_a = er_m_reg;
                mul_b = ev_u_reg;
            end
            ST_EV_P: begin
                mul_a = $signed({13'd0, gamma_reg}) - ONE_Q;
                mul_b = ev_t_reg;
            end
            ST_EV_F2M: begin
                mul_a = ev_u_reg;
                mul_b = ev_tmp_reg;
            end
            ST_EV_G: begin
                mul_a = $signed({13'd0, gamma_reg});
                mul_b = ev_p_reg;
            end
            ST_FACE_M: begin
                mul_a = $signed({1'b0, smax});
                mul_b = face_diff;
            end
            ST_EMIT_M: begin
                mul_a = $signed({15'd0, dt_reg});
                mul_b = emit_diff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        face_diff = sat32(64'(rq_reg[j_reg]) - 64'(lq_reg[j_reg]));
        emit_diff = sat32(64'(em_fr_reg[j_reg]) - 64'(em_fl_reg[j_reg]));
        face_out  = sat32(64'(half_tz(33'(lf_reg[j_reg]) + 33'(rf_reg[j_reg])))
                          - shr_tz(prod_reg, FRAC_BITS + 1));
        emit_res  = sat32(64'(em_c_reg[j_reg]) - 64'(mul_scale(prod_reg)));
        mu_c      = mul_scale(prod_reg);
        ke_c      = half_tz(33'(mu_c));

        sum     = {1'b0, mag(ev_u_reg)} + 33'(ev_c_reg);
        speed_c = (sum > 33'h7fff_ffff) ? {SPEED_W{1'b1}} : sum[SPEED_W-1:0];

        if (unit_neg_reg) begin
            div_res = (dvd_reg > DVD_W'(32'h8000_0000)) ? q_t'(32'h8000_0000)
                                                        : q_t'(~dvd_reg[31:0] + 32'd1);
        end else begin
            div_res = (dvd_reg > DVD_W'(32'h7fff_ffff)) ? q_t'(32'h7fff_ffff)
                                                        : q_t'(dvd_reg[31:0]);
        end

        unit_start = 1'b0;
        unit_sqrt  = 1'b0;
        unit_num   = er_m_reg;
        unit_den   = er_rho_reg;
        case (state_reg)
            ST_EV_U: begin
                unit_start = (er_rho_reg != '0);
            end
            ST_EV_G2: begin
                unit_start = 1'b1;
                unit_num   = mul_scale(prod_reg);
            end
            ST_EV_AD: begin
                unit_start = !unit_busy_reg && !div_res[31] && (div_res != '0);
                unit_sqrt  = 1'b1;
                unit_num   = div_res;
            end
            default: begin
                unit_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge aclk) begin
        logic [32:0] rs_div;
        logic [33:0] dif;
        logic [31:0] rs_sq, trial;
        if (!aresetn) begin
            unit_busy_reg <= 1'b0;
        end else if (unit_start) begin
            unit_busy_reg <= 1'b1;
            unit_sqrt_reg <= unit_sqrt;
            unit_cnt_reg  <= unit_sqrt ? CNT_W'(ROOT_W - 1) : CNT_W'(DVD_W - 1);
            unit_neg_reg  <= unit_num[31] ^ unit_den[31];
            nb_reg        <= mag(unit_den);
            dvd_reg       <= {(unit_sqrt ? 32'(unit_num) : mag(unit_num)),
                              {FRAC_BITS{1'b0}}};
            rem_reg       <= '0;
            root_reg      <= '0;
        end else if (unit_busy_reg) begin
            rs_div = {rem_reg, dvd_reg[DVD_W-1]};
            dif    = {1'b0, rs_div} - {2'b0, nb_reg};
            rs_sq  = {rem_reg[29:0], dvd_reg[DVD_W-1 -: 2]};
            trial  = 32'({root_reg, 2'b01});
            if (unit_sqrt_reg) begin
                dvd_reg <= {dvd_reg[DVD_W-3:0], 2'b00};
                if (rs_sq >= trial) begin
                    rem_reg  <= rs_sq - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rs_sq;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end else begin
                if (!dif[33]) begin
                    rem_reg <= dif[31:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rs_div[31:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                end
            end
            unit_cnt_reg <= unit_cnt_reg - CNT_W'(1);
            if (unit_cnt_reg == '0) begin
                unit_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cells_seen_reg <= '0;
            max_reg        <= '0;
            err_reg        <= 1'b0;
            gamma_reg      <= GAMMA_W'(91750);
            dt_reg         <= DT_W'(6554);
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_GAMMA: gamma_reg <= cfg_wr_data;
                    CFG_DT:    dt_reg    <= cfg_wr_data[DT_W-1:0];
                    default:   gamma_reg <= gamma_reg;
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cur_q_reg[0] <= s_tdata[31:0];
                        cur_q_reg[1] <= s_tdata[63:32];
                        cur_q_reg[2] <= s_tdata[95:64];
                        er_rho_reg   <= s_tdata[31:0];
                        er_m_reg     <= s_tdata[63:32];
                        er_e_reg     <= s_tdata[95:64];
                        k_reg        <= cells_seen_reg;
                        last_reg     <= s_tlast ||
                                        (cells_seen_reg >= IDX_W'(MAX_CELLS - 1));
                        ev_ret_reg   <= ST_CUR_DONE;
                        state_reg    <= ST_EV_U;
                    end
                end
                ST_EV_U: begin
                    ev_u_reg  <= '0;
                    state_reg <= (er_rho_reg != '0) ? ST_EV_UD : ST_EV_MU;
                end
                ST_EV_UD: begin
                    if (!unit_busy_reg) begin
                        ev_u_reg  <= div_res;
                        state_reg <= ST_EV_MU;
                    end
                end
                ST_EV_MU: state_reg <= ST_EV_KE;
                ST_EV_KE: begin
                    ev_mu_reg <= mu_c;
                    ev_t_reg  <= sat32(64'(er_e_reg) - 64'(ke_c));
                    state_reg <= ST_EV_P;
                end
                ST_EV_P: state_reg <= ST_EV_P2;
                ST_EV_P2: begin
                    ev_p_reg  <= mul_scale(prod_reg);
                    state_reg <= ST_EV_F1;
                end
                ST_EV_F1: begin
                    ev_f1_reg  <= sat32(64'(ev_mu_reg) + 64'(ev_p_reg));
                    ev_tmp_reg <= sat32(64'(er_e_reg) + 64'(ev_p_reg));
                    ev_bad_reg <= er_rho_reg[31] || (er_rho_reg == '0) || ev_p_reg[31];
                    state_reg  <= ST_EV_F2M;
                end
                ST_EV_F2M: state_reg <= ST_EV_F2;
                ST_EV_F2: begin
                    ev_f2_reg <= mul_scale(prod_reg);
                    ev_c_reg  <= '0;
                    state_reg <= ev_bad_reg ? ST_EV_SPD : ST_EV_G;
                end
                ST_EV_G:  state_reg <= ST_EV_G2;
                ST_EV_G2: state_reg <= ST_EV_AD;
                ST_EV_AD: begin
                    if (!unit_busy_reg) begin
                        state_reg <= unit_start ? ST_EV_C : ST_EV_SPD;
                    end
                end
                ST_EV_C: begin
                    if (!unit_busy_reg) begin
                        ev_c_reg  <= root_reg;
                        state_reg <= ST_EV_SPD;
                    end
                end
                ST_EV_SPD: begin
                    ev_speed_reg <= speed_c;
                    state_reg    <= ev_ret_reg;
                end
                ST_CUR_DONE: begin
                    cp_speed_reg <= ev_speed_reg;
                    cp_f1_reg    <= ev_f1_reg;
                    cp_f2_reg    <= ev_f2_reg;
                    err_reg      <= err_reg || ev_bad_reg;
                    if (ev_speed_reg > max_reg) begin
                        max_reg <= ev_speed_reg;
                    end
                    if (k_reg == '0) begin
                        first_q_reg <= cur_q_reg;
                        if (last_reg) begin
                            lq_reg       <= cur_q_reg;
                            rq_reg       <= cur_q_reg;
                            lsp_reg      <= ev_speed_reg;
                            rsp_reg      <= ev_speed_reg;
                            lf_reg       <= '{cur_q_reg[1], ev_f1_reg, ev_f2_reg};
                            rf_reg       <= '{cur_q_reg[1], ev_f1_reg, ev_f2_reg};
                            face_ret_reg <= ST_FN_DONE;
                            j_reg        <= '0;
                            state_reg    <= ST_FACE_M;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end else begin
                        er_rho_reg <= prev_q_reg[0];
                        er_m_reg   <= prev_q_reg[1];
                        er_e_reg   <= prev_q_reg[2];
                        ev_ret_reg <= ST_PREV_DONE;
                        state_reg  <= ST_EV_U;
                    end
                end
                ST_PREV_DONE: begin
                    lq_reg       <= prev_q_reg;
                    lsp_reg      <= ev_speed_reg;
                    lf_reg       <= '{prev_q_reg[1], ev_f1_reg, ev_f2_reg};
                    rq_reg       <= cur_q_reg;
                    rsp_reg      <= cp_speed_reg;
                    rf_reg       <= '{cur_q_reg[1], cp_f1_reg, cp_f2_reg};
                    face_ret_reg <= ST_FK_DONE;
                    j_reg        <= '0;
                    state_reg    <= ST_FACE_M;
                end
                ST_FACE_M: state_reg <= ST_FACE_A;
                ST_FACE_A: begin
                    fc_reg[j_reg] <= face_out;
                    if (j_reg == 2'd2) begin
                        state_reg <= face_ret_reg;
                    end else begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= ST_FACE_M;
                    end
                end
                ST_FK_DONE: begin
                    prev_if_reg <= fc_reg;
                    if (k_reg == IDX_W'(1)) begin
                        first_if_reg <= fc_reg;
                        state_reg    <= ST_AFTER_E1;
                    end else begin
                        em_c_reg     <= prev_q_reg;
                        em_fl_reg    <= prev_if_reg;
                        em_fr_reg    <= fc_reg;
                        em_idx_reg   <= k_reg - IDX_W'(1);
                        em_final_reg <= 1'b0;
                        emit_ret_reg <= ST_AFTER_E1;
                        j_reg        <= '0;
                        state_reg    <= ST_EMIT_M;
                    end
                end
                ST_AFTER_E1: begin
                    if (last_reg) begin
                        er_rho_reg <= first_q_reg[0];
                        er_m_reg   <= first_q_reg[1];
                        er_e_reg   <= first_q_reg[2];
                        ev_ret_reg <= ST_FIRST_DONE;
                        state_reg  <= ST_EV_U;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FIRST_DONE: begin
                    lq_reg       <= cur_q_reg;
                    lsp_reg      <= cp_speed_reg;
                    lf_reg       <= '{cur_q_reg[1], cp_f1_reg, cp_f2_reg};
                    rq_reg       <= first_q_reg;
                    rsp_reg      <= ev_speed_reg;
                    rf_reg       <= '{first_q_reg[1], ev_f1_reg, ev_f2_reg};
                    face_ret_reg <= ST_FN_DONE;
                    j_reg        <= '0;
                    state_reg    <= ST_FACE_M;
                end
                ST_FN_DONE: begin
                    em_c_reg <= cur_q_reg;
                    em_fr_reg <= fc_reg;
                    em_idx_reg <= k_reg;
                    j_reg <= '0;
                    state_reg <= ST_EMIT_M;
                    if (k_reg == '0) begin
                        em_fl_reg    <= fc_reg;
                        em_final_reg <= 1'b1;
                        emit_ret_reg <= ST_FINISH;
                    end else begin
                        em_fl_reg    <= prev_if_reg;
                        em_final_reg <= 1'b0;
                        emit_ret_reg <= ST_AFTER_E2;
                    end
                end
                ST_AFTER_E2: begin
                    em_c_reg     <= first_q_reg;
                    em_fl_reg    <= fc_reg;
                    em_fr_reg    <= first_if_reg;
                    em_idx_reg   <= '0;
                    em_final_reg <= 1'b1;
                    emit_ret_reg <= ST_FINISH;
                    j_reg        <= '0;
                    state_reg    <= ST_EMIT_M;
                end
                ST_EMIT_M: state_reg <= ST_EMIT_A;
                ST_EMIT_A: begin
                    res_reg[j_reg] <= emit_res;
                    if (j_reg == 2'd2) begin
                        state_reg <= ST_EMIT_OUT;
                    end else begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= ST_EMIT_M;
                    end
                end
                ST_EMIT_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        out_idx_reg   <= em_idx_reg;
                        out_q_reg     <= res_reg;
                        out_speed_reg <= max_reg;
                        out_err_reg   <= err_reg;
                        out_final_reg <= em_final_reg;
                        state_reg     <= emit_ret_reg;
                    end
                end
                ST_FINISH: begin
                    prev_q_reg <= cur_q_reg;
                    if (last_reg) begin
                        cells_seen_reg <= '0;
                        max_reg        <= '0;
                        err_reg        <= 1'b0;
                    end else begin
                        cells_seen_reg <= k_reg + IDX_W'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_final_reg;
    assign m_tdata  = {4'd0, out_err_reg, out_speed_reg, out_q_reg[2], out_q_reg[1],
                       out_q_reg[0], out_idx_reg};

    a_final_is_cell0: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[IDX_W-1:0] == '0))
        else $error("final transfer is not cell 0");

    a_idle_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !unit_busy_reg)
        else $error("divide/root unit busy while idle");

    a_unit_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_busy_reg |-> (state_reg == ST_EV_UD || state_reg == ST_EV_AD ||
                           state_reg == ST_EV_C))
        else $error("sequencer left a wait state with the unit busy");

endmodule
